// ===== rtl/core/blm_pkg.sv =====
// ---------------------------------------------------------------------------
// blm_pkg: shared definitions for the battery level monitor
// Widths, fixed-point constants, class and register codes, and the structs
// that pass between the sequencer, the classifier and the divider.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package blm_pkg;

    // ADC and fixed-point format
    localparam int ADC_BITS    = 12;
    localparam int FRAC_BITS   = 8;
    localparam int LEVEL_BITS  = ADC_BITS + FRAC_BITS;

    // Filter gain: 6554 / 2^16, about one tenth
    localparam int ALPHA_BITS  = 14;
    localparam int ALPHA_NUM   = 6554;
    localparam int ALPHA_SHIFT = 16;
    localparam int DIFF_BITS   = LEVEL_BITS + 1;
    localparam int PROD_BITS   = DIFF_BITS + ALPHA_BITS - 1;
    localparam int DELTA_BITS  = PROD_BITS - ALPHA_SHIFT;

    // Percent divider
    localparam int PCT_BITS    = 7;
    localparam int PCT_MAX     = 100;
    localparam int NUM_BITS    = LEVEL_BITS + PCT_BITS;
    localparam int DSH_BITS    = LEVEL_BITS + PCT_BITS - 1;
    localparam int CNT_BITS    = $clog2(PCT_BITS);

    // Battery class codes
    localparam logic [2:0] CLS_FULL     = 3'd0;
    localparam logic [2:0] CLS_OK       = 3'd1;
    localparam logic [2:0] CLS_LOW      = 3'd2;
    localparam logic [2:0] CLS_CRITICAL = 3'd3;
    localparam logic [2:0] CLS_DEAD     = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_CRITICAL = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOW      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_NOMINAL  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FULL     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_HYST     = 3'd4;

    // Reset values of the thresholds, in ADC counts
    localparam logic [ADC_BITS-1:0] RST_CRITICAL = ADC_BITS'(2400);
    localparam logic [ADC_BITS-1:0] RST_LOW      = ADC_BITS'(2600);
    localparam logic [ADC_BITS-1:0] RST_NOMINAL  = ADC_BITS'(2800);
    localparam logic [ADC_BITS-1:0] RST_FULL     = ADC_BITS'(3200);
    localparam logic [ADC_BITS-1:0] RST_HYST     = ADC_BITS'(60);

    typedef struct packed {
        logic [ADC_BITS-1:0] critical;
        logic [ADC_BITS-1:0] low;
        logic [ADC_BITS-1:0] nominal;
        logic [ADC_BITS-1:0] full;
        logic [ADC_BITS-1:0] hyst;
    } cfg_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage : blm_pkg

`default_nettype wire

// ===== rtl/core/blm_classify.sv =====
// ---------------------------------------------------------------------------
// blm_classify: five-class hysteresis decision
// Compares the integer part of the level against the thresholds and picks
// the next class from the previous one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blm_classify
    import blm_pkg::*;
(
    input  wire cfg_t                cfg,
    input  wire logic [ADC_BITS-1:0] level_int,
    input  wire logic [2:0]          cls_prev,
    output logic      [2:0]          cls_next
);

    // Two extra bits: threshold plus band carries, full minus band may go negative
    logic signed [ADC_BITS+1:0] v;
    logic signed [ADC_BITS+1:0] t_crit;
    logic signed [ADC_BITS+1:0] t_low;
    logic signed [ADC_BITS+1:0] t_nom;
    logic signed [ADC_BITS+1:0] t_crit_up;
    logic signed [ADC_BITS+1:0] t_low_up;
    logic signed [ADC_BITS+1:0] t_nom_up;
    logic signed [ADC_BITS+1:0] t_full_up;
    logic signed [ADC_BITS+1:0] t_full_dn;

    assign v         = $signed({2'b00, level_int});
    assign t_crit    = $signed({2'b00, cfg.critical});
    assign t_low     = $signed({2'b00, cfg.low});
    assign t_nom     = $signed({2'b00, cfg.nominal});
    assign t_crit_up = t_crit + $signed({2'b00, cfg.hyst});
    assign t_low_up  = t_low + $signed({2'b00, cfg.hyst});
    assign t_nom_up  = t_nom + $signed({2'b00, cfg.hyst});
    assign t_full_up = $signed({2'b00, cfg.full}) + $signed({2'b00, cfg.hyst});
    assign t_full_dn = $signed({2'b00, cfg.full}) - $signed({2'b00, cfg.hyst});

    always_comb
    begin
        cls_next = cls_prev;
        case (cls_prev)
            CLS_DEAD:
            begin
                cls_next = (v >= t_crit_up) ? CLS_CRITICAL : CLS_DEAD;
            end
            CLS_CRITICAL:
            begin
                if (v < t_crit)          cls_next = CLS_DEAD;
                else if (v >= t_low_up)  cls_next = CLS_LOW;
                else                     cls_next = CLS_CRITICAL;
            end
            CLS_LOW:
            begin
                if (v < t_crit)          cls_next = CLS_DEAD;
                else if (v < t_low)      cls_next = CLS_CRITICAL;
                else if (v >= t_nom_up)  cls_next = CLS_OK;
                else                     cls_next = CLS_LOW;
            end
            CLS_OK:
            begin
                if (v < t_crit)          cls_next = CLS_DEAD;
                else if (v < t_low)      cls_next = CLS_CRITICAL;
                else if (v < t_nom)      cls_next = CLS_LOW;
                else if (v >= t_full_up) cls_next = CLS_FULL;
                else                     cls_next = CLS_OK;
            end
            default:
            begin
                // Full, and any unreachable code, behaves as full
                if (v < t_crit)          cls_next = CLS_DEAD;
                else if (v < t_full_dn)  cls_next = CLS_OK;
                else                     cls_next = CLS_FULL;
            end
        endcase
    end

endmodule : blm_classify

`default_nettype wire

// ===== rtl/core/blm_div.sv =====
// ---------------------------------------------------------------------------
// blm_div: iterative restoring divider for the charge percentage
// One shared compare-and-subtract unit retires one quotient bit per cycle,
// most significant first. The quotient must fit in PCT_BITS bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blm_div
    import blm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire div_ctrl_t             ctrl,
    input  wire logic [NUM_BITS-1:0]   numer,
    input  wire logic [LEVEL_BITS-1:0] denom,
    output div_stat_t                  stat,
    output logic      [PCT_BITS-1:0]   quot
);

    logic [NUM_BITS-1:0] rem_reg;
    logic [NUM_BITS-1:0] rem_next;
    logic [DSH_BITS-1:0] dsh_reg;
    logic [DSH_BITS-1:0] dsh_next;
    logic [PCT_BITS-1:0] q_reg;
    logic [PCT_BITS-1:0] q_next;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [CNT_BITS-1:0] cnt_next;
    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;

    logic [NUM_BITS-1:0] dsh_ext;
    logic                fits;

    assign dsh_ext = {1'b0, dsh_reg};
    assign fits    = (rem_reg >= dsh_ext);

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            rem_next  = numer;
            dsh_next  = {denom, (PCT_BITS-1)'(0)};
            q_next    = '0;
            cnt_next  = CNT_BITS'(PCT_BITS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Subtract the shifted divisor when it fits, then advance one bit
            if (fits)
            begin
                rem_next = rem_reg - dsh_ext;
            end
            q_next   = {q_reg[PCT_BITS-2:0], fits};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg;

endmodule : blm_div

`default_nettype wire

// ===== rtl/core/battery_level_monitor.sv =====
// ---------------------------------------------------------------------------
// battery_level_monitor: filtered battery level with hysteresis classes
// Smooths raw ADC samples with a first-order filter, sorts the level into
// full/ok/low/critical/dead and estimates the charge percentage.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel sample_valid/sample_ready carries one raw ADC sample per
//   request. Each accepted sample yields exactly one request on the result
//   channel result_valid/result_ready: filtered level (8 fraction bits),
//   class, percent, the two warning flags and the echoed raw sample.
//   Configuration writes use cfg_valid/cfg_ready with cfg_index (0 critical,
//   1 low, 2 nominal, 3 full, 4 hysteresis band) and cfg_data; cfg_ready is
//   always high, unknown indexes are dropped. Write only while idle.
//   Steps from sample acceptance to result_valid: the filter multiply, the
//   level update, classification, the shared compare-and-subtract divider
//   working out the seven percent bits, the sequencer seeing the divider
//   finish, and the load of the output register. The first sample after
//   reset loads the level directly and skips the multiply and the update.
//   sample_ready is high only while the sequencer is idle; a new sample may
//   be taken while the previous result still waits in the output register.
//   If the receiver stalls, the finished result is held in the sequencer
//   until the output register frees up.
//   Reset (rst_n low, asynchronous) restores the default thresholds, clears
//   the filter, sets the class to ok and drops any pending result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module battery_level_monitor
    import blm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // sample channel
    input  wire logic                    sample_valid,
    output logic                         sample_ready,
    input  wire logic [ADC_BITS-1:0]     sample,
    // result channel
    output logic                         result_valid,
    input  wire logic                    result_ready,
    output logic      [LEVEL_BITS-1:0]   filtered_level,
    output logic      [2:0]              battery_class,
    output logic      [PCT_BITS-1:0]     percent,
    output logic                         is_low,
    output logic                         crit_alarm,
    output logic      [ADC_BITS-1:0]     raw_echo,
    // configuration channel
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [ADC_BITS-1:0]     cfg_data
);

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_ADD  = 6'b000100,
        S_CLS  = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    localparam logic signed [ALPHA_BITS-1:0] ALPHA_S   = ALPHA_BITS'(ALPHA_NUM);
    localparam logic signed [PROD_BITS-1:0]  ROUND_S   = PROD_BITS'(1 << (ALPHA_SHIFT - 1));
    localparam logic [NUM_BITS-1:0]          PCT_MUL   = NUM_BITS'(PCT_MAX);
    localparam logic [PCT_BITS-1:0]          PCT_FULL  = PCT_BITS'(PCT_MAX);

    state_t                 state_reg;
    state_t                 state_next;

    cfg_t                   cfg_reg;
    logic [LEVEL_BITS-1:0]  level_reg;
    logic [2:0]             class_reg;
    logic                   primed_reg;
    logic [ADC_BITS-1:0]    raw_reg;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic                   zero_reg;
    logic                   sat_reg;

    // Output register
    logic                   out_valid_reg;
    logic [LEVEL_BITS-1:0]  out_level_reg;
    logic [2:0]             out_class_reg;
    logic [PCT_BITS-1:0]    out_pct_reg;
    logic [ADC_BITS-1:0]    out_raw_reg;

    logic                   sample_acc;
    logic                   out_load;

    // Filter datapath
    logic signed [DIFF_BITS-1:0]  diff;
    logic signed [PROD_BITS:0]    prod_full;
    logic signed [PROD_BITS-1:0]  prod_round;
    logic signed [DELTA_BITS-1:0] delta;
    logic signed [DIFF_BITS-1:0]  level_upd;

    // Percent preparation
    logic [LEVEL_BITS-1:0]  crit_fix;
    logic [LEVEL_BITS-1:0]  span_fix;
    logic [LEVEL_BITS-1:0]  above;
    logic [NUM_BITS-1:0]    numer;
    logic                   pct_zero;
    logic                   pct_sat;

    logic [2:0]             cls_next;
    div_ctrl_t              div_ctrl;
    div_stat_t              div_stat;
    logic [PCT_BITS-1:0]    div_quot;

    assign cfg_ready    = 1'b1;
    assign sample_ready = (state_reg == S_IDLE);
    assign sample_acc   = sample_valid && sample_ready;
    assign out_load     = (state_reg == S_DONE) && (!out_valid_reg || result_ready);

    // level += round(alpha * (sample - level)), halves toward +inf
    assign diff       = $signed({1'b0, raw_reg, FRAC_BITS'(0)})
                        - $signed({1'b0, level_reg});
    assign prod_full  = diff * ALPHA_S;
    assign prod_round = prod_reg + ROUND_S;
    assign delta      = prod_round[PROD_BITS-1:ALPHA_SHIFT];
    assign level_upd  = $signed({1'b0, level_reg})
                        + {{(DIFF_BITS-DELTA_BITS){delta[DELTA_BITS-1]}}, delta};

    // Percent = (level - crit) * 100 / (full - crit), clamped
    assign crit_fix = {cfg_reg.critical, FRAC_BITS'(0)};
    assign span_fix = {cfg_reg.full - cfg_reg.critical, FRAC_BITS'(0)};
    assign above    = level_reg - crit_fix;
    assign numer    = {PCT_BITS'(0), above} * PCT_MUL;
    assign pct_zero = (cfg_reg.full <= cfg_reg.critical) || (level_reg <= crit_fix);
    assign pct_sat  = (above >= span_fix);

    assign div_ctrl.start = (state_reg == S_CLS);

    blm_classify u_classify (
        .cfg       (cfg_reg),
        .level_int (level_reg[LEVEL_BITS-1:FRAC_BITS]),
        .cls_prev  (class_reg),
        .cls_next  (cls_next)
    );

    blm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .numer (numer),
        .denom (span_fix),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_acc)
                begin
                    state_next = primed_reg ? S_MUL : S_CLS;
                end
            end
            S_MUL:  state_next = S_ADD;
            S_ADD:  state_next = S_CLS;
            S_CLS:  state_next = S_DIV;
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cfg_reg.critical <= RST_CRITICAL;
            cfg_reg.low      <= RST_LOW;
            cfg_reg.nominal  <= RST_NOMINAL;
            cfg_reg.full     <= RST_FULL;
            cfg_reg.hyst     <= RST_HYST;
            level_reg        <= '0;
            class_reg        <= CLS_OK;
            primed_reg       <= 1'b0;
            raw_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Drop writes to unknown indexes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CRITICAL: cfg_reg.critical <= cfg_data;
                    REG_LOW:      cfg_reg.low      <= cfg_data;
                    REG_NOMINAL:  cfg_reg.nominal  <= cfg_data;
                    REG_FULL:     cfg_reg.full     <= cfg_data;
                    REG_HYST:     cfg_reg.hyst     <= cfg_data;
                    default:      ;
                endcase
            end

            if (sample_acc)
            begin
                raw_reg <= sample;
                if (!primed_reg)
                begin
                    // First sample loads the level directly
                    level_reg  <= {sample, FRAC_BITS'(0)};
                    primed_reg <= 1'b1;
                end
            end

            if (state_reg == S_ADD)
            begin
                level_reg <= level_upd[LEVEL_BITS-1:0];
            end

            if (state_reg == S_CLS)
            begin
                class_reg <= cls_next;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
        begin
            prod_reg <= prod_full[PROD_BITS-1:0];
        end
        if (state_reg == S_CLS)
        begin
            zero_reg <= pct_zero;
            sat_reg  <= pct_sat;
        end
        if (out_load)
        begin
            out_level_reg <= level_reg;
            out_class_reg <= class_reg;
            out_pct_reg   <= zero_reg ? '0 : (sat_reg ? PCT_FULL : div_quot);
            out_raw_reg   <= raw_reg;
        end
    end

    assign result_valid   = out_valid_reg;
    assign filtered_level = out_level_reg;
    assign battery_class  = out_class_reg;
    assign percent        = out_pct_reg;
    assign is_low         = (out_class_reg >= CLS_LOW);
    assign crit_alarm     = (out_class_reg >= CLS_CRITICAL);
    assign raw_echo       = out_raw_reg;

endmodule : battery_level_monitor

`default_nettype wire

// ===== rtl/core/blm_checker.sv =====
// ---------------------------------------------------------------------------
// blm_checker: port-level checks for the battery level monitor
// Watches the top level's channels and result fields over time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blm_checker
    import blm_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  sample_valid,
    input wire logic                  sample_ready,
    input wire logic                  result_valid,
    input wire logic                  result_ready,
    input wire logic [LEVEL_BITS-1:0] filtered_level,
    input wire logic [2:0]            battery_class,
    input wire logic [PCT_BITS-1:0]   percent,
    input wire logic                  is_low,
    input wire logic                  crit_alarm
);

    // A stalled result request holds its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(filtered_level) && $stable(percent)
            && $stable(battery_class))
        else $error("result changed while stalled");

    // Percent never exceeds the clamp
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> percent <= PCT_BITS'(PCT_MAX))
        else $error("percent out of range");

    // Warning flags follow the class
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (is_low == (battery_class >= CLS_LOW))
            && (crit_alarm == (battery_class >= CLS_CRITICAL)))
        else $error("warning flags disagree with class");

    // Accepting a sample busies the block
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("ready right after accepting a sample");

endmodule : blm_checker

bind battery_level_monitor blm_checker u_blm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .filtered_level (filtered_level),
    .battery_class  (battery_class),
    .percent        (percent),
    .is_low         (is_low),
    .crit_alarm     (crit_alarm)
);

`default_nettype wire

// ===== dv/battery_level_monitor_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// battery_level_monitor_test: self-checking bench for the battery monitor
// Drives raw ADC samples and threshold writes, and computes the filtered
// level, class, percent and flags of every sample in a model kept in the
// bench. Each result request is checked field by field against the oldest
// prediction. Both sides idle at random, and one burst stalls the receiver
// long enough to back the block up into its input.
// ---------------------------------------------------------------------------
module battery_level_monitor_test;
    import blm_pkg::*;

    localparam int     MAX_WAIT     = 8;       // longest idle draw, either side
    localparam int     HOLD_CYCLES  = 400;     // long receiver stall
    localparam int     DRAIN_CYCLES = 16;      // wait after the last result
    localparam int     CYCLE_LIMIT  = 400000;  // far above the slowest correct run
    localparam int     PHASES       = 9;
    localparam int     PHASE_ITEMS  = 95;
    localparam int     BURST_ITEMS  = 80;
    localparam int     MAX_REPORTS  = 10;
    localparam int     ADC_MAX      = (1 << ADC_BITS) - 1;
    localparam logic [ADC_BITS-1:0] ADC_TOP = ADC_BITS'(ADC_MAX);
    localparam longint ROUND_HALF   = longint'(1) <<< (ALPHA_SHIFT - 1);

    typedef enum int {
        CFG_ORDERED,
        CFG_RANDOM,
        CFG_ALL_MAX,
        CFG_ALL_ZERO
    } cfg_mode_e;

    // One result request, in port order
    typedef struct packed {
        logic [LEVEL_BITS-1:0] level;
        logic [2:0]            cls;
        logic [PCT_BITS-1:0]   pct;
        logic                  low_flag;
        logic                  crit_flag;
        logic [ADC_BITS-1:0]   raw;
    } reading_t;

    // Block ports; every input holds a known value from time zero
    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    sample_valid = 1'b0;
    wire                     sample_ready;
    logic [ADC_BITS-1:0]     sample       = '0;
    wire                     result_valid;
    logic                    result_ready = 1'b0;
    wire  [LEVEL_BITS-1:0]   filtered_level;
    wire  [2:0]              battery_class;
    wire  [PCT_BITS-1:0]     percent;
    wire                     is_low;
    wire                     crit_alarm;
    wire  [ADC_BITS-1:0]     raw_echo;
    logic                    cfg_valid    = 1'b0;
    wire                     cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index    = '0;
    logic [ADC_BITS-1:0]     cfg_data     = '0;

    // Model copy of the thresholds and the filter/classifier state
    logic [ADC_BITS-1:0]     th_crit;
    logic [ADC_BITS-1:0]     th_low;
    logic [ADC_BITS-1:0]     th_nom;
    logic [ADC_BITS-1:0]     th_full;
    logic [ADC_BITS-1:0]     th_hyst;
    logic [LEVEL_BITS-1:0]   lvl_state;
    logic [2:0]              cls_state;
    logic                    primed_state;

    reading_t                expected_readings[$];
    int                      errors       = 0;
    int                      cycle_count  = 0;
    bit                      src_steady   = 1'b0;  // sender offers back to back
    bit                      sink_steady  = 1'b0;  // receiver never idles
    int                      hold_left    = 0;     // cycles of forced receiver stall
    logic                    sink_hold    = 1'b0;
    int                      walk_target  = 2048;  // level the random walk aims at

    battery_level_monitor u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .sample         (sample),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .filtered_level (filtered_level),
        .battery_class  (battery_class),
        .percent        (percent),
        .is_low         (is_low),
        .crit_alarm     (crit_alarm),
        .raw_echo       (raw_echo),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Count down a requested receiver stall in cycles
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            sink_hold <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            sink_hold <= 1'b0;
        end
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Prediction
    // -----------------------------------------------------------------------

    // ADC counts to level units (8 fraction bits), kept signed and wide
    function automatic longint counts_fx(input longint counts);
        return counts <<< FRAC_BITS;
    endfunction

    // Move a tenth of the way to the sample; product rounded to nearest,
    // halves toward +inf, so the level never overshoots the sample
    function automatic logic [LEVEL_BITS-1:0] filtered_next(
        input logic [LEVEL_BITS-1:0] lvl,
        input logic [ADC_BITS-1:0]   s
    );
        longint prod;
        longint delta;
        prod = (counts_fx(longint'(s)) - longint'(lvl)) * ALPHA_NUM;
        if (prod >= 0)
            delta = (prod + ROUND_HALF) >>> ALPHA_SHIFT;
        else
            delta = -((ROUND_HALF - 1 - prod) >>> ALPHA_SHIFT);
        return LEVEL_BITS'(longint'(lvl) + delta);
    endfunction

    // Hysteresis classifier; downward moves at the exact thresholds, upward
    // moves need the band on top. Signed compares, so full - band may go
    // negative and then full only leaves by dropping to dead.
    function automatic logic [2:0] next_class(input longint v, input logic [2:0] cls);
        longint crit_fx;
        longint low_fx;
        longint nom_fx;
        longint full_fx;
        longint hyst_fx;
        crit_fx = counts_fx(longint'(th_crit));
        low_fx  = counts_fx(longint'(th_low));
        nom_fx  = counts_fx(longint'(th_nom));
        full_fx = counts_fx(longint'(th_full));
        hyst_fx = counts_fx(longint'(th_hyst));
        case (cls)
            CLS_DEAD:
                return (v >= crit_fx + hyst_fx) ? CLS_CRITICAL : CLS_DEAD;
            CLS_CRITICAL:
            begin
                if (v < crit_fx)
                    return CLS_DEAD;
                if (v >= low_fx + hyst_fx)
                    return CLS_LOW;
                return CLS_CRITICAL;
            end
            CLS_LOW:
            begin
                if (v < crit_fx)
                    return CLS_DEAD;
                if (v < low_fx)
                    return CLS_CRITICAL;
                if (v >= nom_fx + hyst_fx)
                    return CLS_OK;
                return CLS_LOW;
            end
            CLS_OK:
            begin
                if (v < crit_fx)
                    return CLS_DEAD;
                if (v < low_fx)
                    return CLS_CRITICAL;
                if (v < nom_fx)
                    return CLS_LOW;
                if (v >= full_fx + hyst_fx)
                    return CLS_FULL;
                return CLS_OK;
            end
            default:  // full, and any unused code behaves as full
            begin
                if (v < crit_fx)
                    return CLS_DEAD;
                if (v < full_fx - hyst_fx)
                    return CLS_OK;
                return CLS_FULL;
            end
        endcase
    endfunction

    // Truncated percent between critical and full, clamped to 0..100
    function automatic logic [PCT_BITS-1:0] charge_percent(input logic [LEVEL_BITS-1:0] lvl);
        longint base;
        longint span;
        longint q;
        if (th_full <= th_crit)
            return '0;
        base = counts_fx(longint'(th_crit));
        if (longint'(lvl) <= base)
            return '0;
        span = counts_fx(longint'(th_full) - longint'(th_crit));
        q = ((longint'(lvl) - base) * PCT_MAX) / span;
        if (q > PCT_MAX)
            q = PCT_MAX;
        return PCT_BITS'(q);
    endfunction

    // Advance the model by one accepted sample and return its result
    function automatic reading_t predict_reading(input logic [ADC_BITS-1:0] s);
        reading_t r;
        if (!primed_state)
        begin
            // first sample after reset loads the level directly
            lvl_state    = LEVEL_BITS'(counts_fx(longint'(s)));
            primed_state = 1'b1;
        end
        else
        begin
            lvl_state = filtered_next(lvl_state, s);
        end
        cls_state   = next_class(longint'(lvl_state), cls_state);
        r.level     = lvl_state;
        r.cls       = cls_state;
        r.pct       = charge_percent(lvl_state);
        r.low_flag  = (cls_state >= CLS_LOW);
        r.crit_flag = (cls_state >= CLS_CRITICAL);
        r.raw       = s;
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Checking
    // -----------------------------------------------------------------------

    function automatic void note_error(input string msg);
        if (errors < MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endfunction

    // Compare one accepted result request with the oldest prediction
    task automatic check_reading();
        reading_t got;
        reading_t want;
        got.level     = filtered_level;
        got.cls       = battery_class;
        got.pct       = percent;
        got.low_flag  = is_low;
        got.crit_flag = crit_alarm;
        got.raw       = raw_echo;
        if (expected_readings.size() == 0)
        begin
            note_error($sformatf("result with nothing outstanding: level %0d class %0d raw %0d",
                                 got.level, got.cls, got.raw));
        end
        else
        begin
            want = expected_readings.pop_front();
            if (got.level !== want.level || got.cls !== want.cls || got.pct !== want.pct ||
                got.low_flag !== want.low_flag || got.crit_flag !== want.crit_flag ||
                got.raw !== want.raw)
            begin
                note_error($sformatf({"mismatch: exp level %0d class %0d pct %0d low %0b ",
                                      "crit %0b raw %0d / got level %0d class %0d pct %0d ",
                                      "low %0b crit %0b raw %0d"},
                                     want.level, want.cls, want.pct, want.low_flag,
                                     want.crit_flag, want.raw, got.level, got.cls, got.pct,
                                     got.low_flag, got.crit_flag, got.raw));
            end
        end
    endtask

    // Receiver: idle a random number of cycles per request, hold ready low
    // while a forced stall runs, then take one request and check it
    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = sink_steady ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall != 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            do
            begin
                result_ready <= !sink_hold;
                @(posedge clk);
            end
            while (!(result_valid && result_ready));
            check_reading();
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    // Offer one sample after a random gap and hold it until accepted. Valid
    // stays high on return, so a back-to-back caller just swaps the payload.
    task automatic send_sample(input logic [ADC_BITS-1:0] s);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        @(posedge clk);
        while (!sample_ready) @(posedge clk);
        expected_readings.push_back(predict_reading(s));
    endtask

    // Drop the sample request and wait until every prediction is matched;
    // each sample yields exactly one result, so the block is idle then
    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge clk);
    endtask

    // One register write; unknown indexes leave the model untouched
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [ADC_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_CRITICAL: th_crit = val;
            REG_LOW:      th_low  = val;
            REG_NOMINAL:  th_nom  = val;
            REG_FULL:     th_full = val;
            REG_HYST:     th_hyst = val;
            default:      ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_thresholds(input logic [ADC_BITS-1:0] crit_v,
                                   input logic [ADC_BITS-1:0] low_v,
                                   input logic [ADC_BITS-1:0] nom_v,
                                   input logic [ADC_BITS-1:0] full_v,
                                   input logic [ADC_BITS-1:0] hyst_v);
        write_reg(REG_CRITICAL, crit_v);
        write_reg(REG_LOW, low_v);
        write_reg(REG_NOMINAL, nom_v);
        write_reg(REG_FULL, full_v);
        write_reg(REG_HYST, hyst_v);
    endtask

    // Random walk around the thresholds: now and then retarget near one of
    // them, jitter around the target, and mix in full-range noise
    function automatic logic [ADC_BITS-1:0] walk_sample();
        int band;
        int s;
        band = int'(th_hyst) + 40;
        if ($urandom_range(0, 14) == 0)
        begin
            case ($urandom_range(0, 4))
                0:       walk_target = int'(th_crit);
                1:       walk_target = int'(th_low);
                2:       walk_target = int'(th_nom);
                3:       walk_target = int'(th_full);
                default: walk_target = $urandom_range(0, ADC_MAX);
            endcase
            walk_target = walk_target + int'($urandom_range(0, 4 * band)) - 2 * band;
        end
        if ($urandom_range(0, 4) == 0)
            s = $urandom_range(0, ADC_MAX);
        else
            s = walk_target + int'($urandom_range(0, 60)) - 30;
        if (s < 0)
            s = 0;
        if (s > ADC_MAX)
            s = ADC_MAX;
        return ADC_BITS'(s);
    endfunction

    task automatic configure_phase(input cfg_mode_e mode);
        int c;
        int l;
        int n;
        int f;
        case (mode)
            CFG_ORDERED:
            begin
                c = $urandom_range(300, 2500);
                l = c + $urandom_range(50, 400);
                n = l + $urandom_range(50, 400);
                f = n + $urandom_range(100, 800);
                if (f > ADC_MAX)
                    f = ADC_MAX;
                load_thresholds(ADC_BITS'(c), ADC_BITS'(l), ADC_BITS'(n), ADC_BITS'(f),
                                ADC_BITS'($urandom_range(0, 150)));
            end
            CFG_RANDOM:
                load_thresholds(ADC_BITS'($urandom_range(0, ADC_MAX)),
                                ADC_BITS'($urandom_range(0, ADC_MAX)),
                                ADC_BITS'($urandom_range(0, ADC_MAX)),
                                ADC_BITS'($urandom_range(0, ADC_MAX)),
                                ADC_BITS'($urandom_range(0, ADC_MAX)));
            CFG_ALL_MAX:
                load_thresholds(ADC_TOP, ADC_TOP, ADC_TOP, ADC_TOP, ADC_TOP);
            default:
                load_thresholds('0, '0, '0, '0, '0);
        endcase
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // First sample loads the level; then walk down through every class with
    // zeros and back up with full-scale samples, on the reset thresholds
    task automatic test_first_sample_and_extremes();
        send_sample(ADC_TOP);
        repeat (6) send_sample('0);
        repeat (5) send_sample(ADC_TOP);
    endtask

    // Reach full with no band, then widen the band past full: the battery
    // must stay full until it falls all the way to dead
    task automatic test_band_wider_than_full();
        wait_idle();
        write_reg(REG_HYST, '0);
        write_reg(REG_FULL, 3000);
        repeat (2) send_sample(ADC_TOP);
        wait_idle();
        write_reg(REG_HYST, ADC_TOP);
        repeat (3) send_sample('0);
    endtask

    // Thresholds out of order, full below critical
    task automatic test_unordered_thresholds();
        wait_idle();
        load_thresholds(3000, 1000, 3500, 500, 100);
        send_sample(2000);
        send_sample(ADC_TOP);
        send_sample('0);
        send_sample(3200);
    endtask

    // Full equal to critical: percent pinned at zero
    task automatic test_degenerate_range();
        wait_idle();
        load_thresholds(2048, 2300, 2600, 2048, 30);
        send_sample(3000);
        send_sample(1000);
    endtask

    // Writes to indexes past the register file must change nothing
    task automatic test_unused_indexes();
        wait_idle();
        load_thresholds(RST_CRITICAL, RST_LOW, RST_NOMINAL, RST_FULL, RST_HYST);
        for (int i = int'(REG_HYST) + 1; i < (1 << CFG_IDX_BITS); i++)
            write_reg(CFG_IDX_BITS'(i), ADC_BITS'($urandom_range(0, ADC_MAX)));
        send_sample(2900);
        send_sample(2500);
    endtask

    // Phases of random walks, each on a fresh setting of the thresholds;
    // one phase runs with no idling on either side
    task automatic test_random_phases();
        cfg_mode_e mode;
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            if (p == 2)
                mode = CFG_ALL_MAX;
            else if (p == 5)
                mode = CFG_ALL_ZERO;
            else if (p % 3 == 1)
                mode = CFG_RANDOM;
            else
                mode = CFG_ORDERED;
            configure_phase(mode);
            src_steady  = (p == 3);
            sink_steady = (p == 3 || p == 6);
            walk_target = int'(th_nom);
            repeat (PHASE_ITEMS) send_sample(walk_sample());
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // Stall the receiver for a long stretch while samples keep coming back
    // to back, so the output register and sequencer fill and input stalls
    task automatic test_receiver_backpressure();
        wait_idle();
        configure_phase(CFG_ORDERED);
        walk_target = int'(th_low);
        src_steady  = 1'b1;
        hold_left  <= HOLD_CYCLES;
        repeat (BURST_ITEMS) send_sample(walk_sample());
        src_steady  = 1'b0;
    endtask

    initial
    begin : main
        th_crit      = RST_CRITICAL;
        th_low       = RST_LOW;
        th_nom       = RST_NOMINAL;
        th_full      = RST_FULL;
        th_hyst      = RST_HYST;
        lvl_state    = '0;
        cls_state    = CLS_OK;
        primed_state = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_sample_and_extremes();
        test_band_wider_than_full();
        test_unordered_thresholds();
        test_degenerate_range();
        test_unused_indexes();
        test_random_phases();
        test_receiver_backpressure();

        // hold on past the latency to catch any stray result
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_readings.size() != 0)
            note_error($sformatf("%0d results never arrived", expected_readings.size()));

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
